[rtl/core/ctapat_pkg.sv]
// Shared widths, constants and command types for the A*P*A^T transform core.
`timescale 1ns / 1ps

package ctapat_pkg;

    localparam int DIM_DEF    = 5;
    localparam int PLANES_DEF = 8;

    localparam int VAL_W   = 32;
    localparam int SLICE_W = 3;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int FRAC    = 16;

    localparam int XW      = 52;
    localparam int XLO_W   = 26;
    localparam int MUL_A_W = 33;
    localparam int PROD_W  = MUL_A_W + VAL_W;
    localparam int ACC_W   = 88;

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC - 1);
    localparam logic [VAL_W-1:0] SAT_MAX    = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN    = {1'b1, {(VAL_W - 1){1'b0}}};

    typedef enum logic {
        PH_XPROD,
        PH_OUT
    } t_phase;

    typedef struct packed {
        logic              valid;
        t_phase            phase;
        logic              first;
        logic              last;
        logic              half;
        logic              fin;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [ADDR_W-1:0] dst;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_cmd;

    typedef struct packed {
        logic              wr_a;
        logic              wr_p;
        logic [ADDR_W-1:0] addr;
    } t_ld;

    typedef struct packed {
        logic busy;
        logic slot_free;
    } t_stat;

endpackage

[rtl/core/ctapat_ctrl.sv]
// Sequencer: load counting, loop counters and step commands for the datapath.
`timescale 1ns / 1ps

module ctapat_ctrl #(
    parameter int DIM = ctapat_pkg::DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ctapat_pkg::t_stat  i_stat,
    output ctapat_pkg::t_ld    o_ld,
    output ctapat_pkg::t_cmd   o_cmd
);
    import ctapat_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int LW    = $clog2(2 * CELLS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_P1_RUN,
        ST_P1_DRAIN,
        ST_P2_SLOT,
        ST_P2_RUN,
        ST_P2_DRAIN
    } t_state;

    t_state          r_state;
    logic [LW-1:0]   r_cnt;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_j;
    logic [IW-1:0]   r_k;
    logic            r_h;

    logic            accept;
    logic            k_end;
    logic            j_end;
    logic            i_end;
    logic [AW-1:0]   ld_addr;

    function automatic logic [AW-1:0] f_cell(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * AW'(DIM) + AW'(c);
    endfunction

    assign accept = i_valid && (r_state == ST_LOAD);
    assign o_stall = (r_state != ST_LOAD);
    assign k_end = (r_k == IW'(DIM - 1));
    assign j_end = (r_j == IW'(DIM - 1));
    assign i_end = (r_i == IW'(DIM - 1));

    always_comb begin
        if (r_cnt < LW'(CELLS)) begin
            ld_addr = AW'(r_cnt);
        end else begin
            ld_addr = AW'(r_cnt - LW'(CELLS));
        end
        o_ld.wr_a = accept && (r_cnt < LW'(CELLS));
        o_ld.wr_p = accept && (r_cnt >= LW'(CELLS));
        o_ld.addr = ADDR_W'(ld_addr);
    end

    always_comb begin
        o_cmd.valid = (r_state == ST_P1_RUN) || (r_state == ST_P2_RUN);
        o_cmd.row   = IDX_W'(r_i);
        o_cmd.col   = IDX_W'(r_j);
        o_cmd.dst   = ADDR_W'(f_cell(r_i, r_j));
        o_cmd.fin   = i_end && j_end;
        if (r_state == ST_P2_RUN) begin
            o_cmd.phase  = PH_OUT;
            o_cmd.first  = (r_k == '0) && !r_h;
            o_cmd.last   = k_end && r_h;
            o_cmd.half   = r_h;
            o_cmd.a_addr = ADDR_W'(f_cell(r_j, r_k));
            o_cmd.b_addr = ADDR_W'(f_cell(r_i, r_k));
        end else begin
            o_cmd.phase  = PH_XPROD;
            o_cmd.first  = (r_k == '0);
            o_cmd.last   = k_end;
            o_cmd.half   = 1'b0;
            o_cmd.a_addr = ADDR_W'(f_cell(r_i, r_k));
            o_cmd.b_addr = ADDR_W'(f_cell(r_k, r_j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_h     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (r_cnt == LW'(2 * CELLS - 1)) begin
                            r_cnt   <= '0;
                            r_state <= ST_P1_RUN;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_P1_RUN: begin
                    if (k_end) begin
                        r_k <= '0;
                        if (j_end) begin
                            r_j <= '0;
                            if (i_end) begin
                                r_i     <= '0;
                                r_state <= ST_P1_DRAIN;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_P1_DRAIN: begin
                    if (!i_stat.busy) begin
                        r_state <= ST_P2_SLOT;
                    end
                end
                ST_P2_SLOT: begin
                    if (i_stat.slot_free) begin
                        r_state <= ST_P2_RUN;
                    end
                end
                ST_P2_RUN: begin
                    r_h <= !r_h;
                    if (r_h) begin
                        if (k_end) begin
                            r_k     <= '0;
                            r_state <= ST_P2_DRAIN;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                ST_P2_DRAIN: begin
                    if (!i_stat.busy) begin
                        if (j_end) begin
                            r_j <= '0;
                            if (i_end) begin
                                r_i     <= '0;
                                r_state <= ST_LOAD;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= ST_P2_SLOT;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_P2_SLOT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

[rtl/core/ctapat_dp.sv]
// Datapath: element memories, shared multiplier, accumulator, rounding and result register.
`timescale 1ns / 1ps

module ctapat_dp #(
    parameter int DIM    = ctapat_pkg::DIM_DEF,
    parameter int PLANES = ctapat_pkg::PLANES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ctapat_pkg::VAL_W-1:0]        i_value,
    input  logic [ctapat_pkg::SLICE_W-1:0]      i_slice,
    input  ctapat_pkg::t_ld                     i_ld,
    input  ctapat_pkg::t_cmd                    i_cmd,
    output ctapat_pkg::t_stat                   o_stat,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [ctapat_pkg::VAL_W-1:0]        o_result_value,
    output logic [ctapat_pkg::IDX_W-1:0]        o_row,
    output logic [ctapat_pkg::IDX_W-1:0]        o_column,
    output logic [ctapat_pkg::SLICE_W-1:0]      o_result_slice,
    output logic                                o_last
);
    import ctapat_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [VAL_W-1:0]          r_a_mem [CELLS];
    logic [VAL_W-1:0]          r_p_mem [CELLS];
    logic [XW-1:0]             r_x_mem [CELLS];

    logic [VAL_W-1:0]          r_a_q;
    logic [VAL_W-1:0]          r_p_q;
    logic [XW-1:0]             r_x_q;
    logic [SLICE_W-1:0]        r_slice;

    t_cmd                      r_s1;
    t_cmd                      r_s2;
    t_cmd                      r_s3;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [VAL_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   rsum;
    logic signed [ACC_W-1:0]   rnd;
    logic [VAL_W-1:0]          sat;
    logic                      in_range;
    logic                      done;

    logic                      r_out_valid;
    logic [VAL_W-1:0]          r_out_value;
    logic [IDX_W-1:0]          r_out_row;
    logic [IDX_W-1:0]          r_out_col;
    logic [SLICE_W-1:0]        r_out_slice;
    logic                      r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_ld.wr_a) begin
            r_a_mem[i_ld.addr[AW-1:0]] <= i_value;
        end
        if (i_ld.wr_p) begin
            r_p_mem[i_ld.addr[AW-1:0]] <= i_value;
        end
        if (done && (r_s3.phase == PH_XPROD)) begin
            r_x_mem[r_s3.dst[AW-1:0]] <= rnd[XW-1:0];
        end
        r_a_q <= r_a_mem[i_cmd.a_addr[AW-1:0]];
        r_p_q <= r_p_mem[i_cmd.b_addr[AW-1:0]];
        r_x_q <= r_x_mem[i_cmd.b_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
        end else if (i_ld.wr_a) begin
            if ({1'b0, i_slice} >= (SLICE_W + 1)'(PLANES)) begin
                r_slice <= SLICE_W'(PLANES - 1);
            end else begin
                r_slice <= i_slice;
            end
        end
    end

    always_comb begin
        if (r_s1.phase == PH_XPROD) begin
            op_a = {r_a_q[VAL_W-1], r_a_q};
            op_b = r_p_q;
        end else begin
            if (r_s1.half) begin
                op_a = {{(MUL_A_W - (XW - XLO_W)){r_x_q[XW-1]}}, r_x_q[XW-1:XLO_W]};
            end else begin
                op_a = {(MUL_A_W - XLO_W)'(0), r_x_q[XLO_W-1:0]};
            end
            op_b = r_a_q;
        end
    end

    always_comb begin
        prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        term     = r_s2.half ? (prod_ext <<< XLO_W) : prod_ext;
        n_acc    = (r_s2.first ? '0 : r_acc) + term;
        rsum     = r_acc + ROUND_BIAS;
        rnd      = rsum >>> FRAC;
        in_range = (&rnd[ACC_W-1:VAL_W-1]) || !(|rnd[ACC_W-1:VAL_W-1]);
        if (in_range) begin
            sat = rnd[VAL_W-1:0];
        end else if (rnd[ACC_W-1]) begin
            sat = SAT_MIN;
        end else begin
            sat = SAT_MAX;
        end
        done = r_s3.valid && r_s3.last;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= i_cmd;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && (r_s3.phase == PH_OUT)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && (r_s3.phase == PH_OUT)) begin
            r_out_value <= sat;
            r_out_row   <= r_s3.row;
            r_out_col   <= r_s3.col;
            r_out_slice <= r_slice;
            r_out_last  <= r_s3.fin;
        end
    end

    assign o_stat.busy      = r_s1.valid || r_s2.valid || r_s3.valid;
    assign o_stat.slot_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_row          = r_out_row;
    assign o_column       = r_out_col;
    assign o_result_slice = r_out_slice;
    assign o_last         = r_out_last;

endmodule

[rtl/core/covariance_transform_a_p_at_core.sv]
// Top level of the covariance propagation core P' = A*P*A^T.
//
//   channel  direction  handshake            beat payload
//   input    in         i_valid / o_stall    i_value, i_slice
//   output   out        o_valid / i_stall    o_result_value, o_row, o_column,
//                                            o_result_slice, o_last
//
// Loading accepts one input beat per cycle while o_stall is low; a job is 2*DIM*DIM beats.
// X = A*P runs on the shared multiplier at one step a cycle, DIM^3 steps, then drains.
// Each result takes 2*DIM multiplier steps (two partial products per term), after an output
// slot check and followed by a pipeline drain.
// Input stall is high from the cycle after the last P beat until the cycle after the last
// result enters the output register.
// An output stall holds the result register and delays the next result; reset is synchronous.
`timescale 1ns / 1ps

module covariance_transform_a_p_at_core #(
    parameter int DIM    = ctapat_pkg::DIM_DEF,
    parameter int PLANES = ctapat_pkg::PLANES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ctapat_pkg::VAL_W-1:0]      i_value,
    input  logic [ctapat_pkg::SLICE_W-1:0]    i_slice,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ctapat_pkg::VAL_W-1:0]      o_result_value,
    output logic [ctapat_pkg::IDX_W-1:0]      o_row,
    output logic [ctapat_pkg::IDX_W-1:0]      o_column,
    output logic [ctapat_pkg::SLICE_W-1:0]    o_result_slice,
    output logic                              o_last
);
    import ctapat_pkg::*;

    t_ld   ld;
    t_cmd  cmd;
    t_stat stat;

    ctapat_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_ld    (ld),
        .o_cmd   (cmd)
    );

    ctapat_dp #(
        .DIM    (DIM),
        .PLANES (PLANES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_slice        (i_slice),
        .i_ld           (ld),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_result_slice (o_result_slice),
        .o_last         (o_last)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the A*P*A^T covariance propagation core.
`timescale 1ns / 1ps

module testbench;
    import ctapat_pkg::*;

    localparam int DIM        = DIM_DEF;
    localparam int PLANES     = PLANES_DEF;
    localparam int CELLS      = DIM * DIM;
    localparam int JOBS       = 8;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 300000;
    localparam int DRAIN_WAIT = 120;

    localparam int EL_SMALL  = 0;
    localparam int EL_CORNER = 1;
    localparam int EL_WIDE   = 2;
    localparam int EL_MIXED  = 3;

    localparam int ST_NONE     = 0;
    localparam int ST_RANDOM   = 1;
    localparam int ST_HEAVY    = 2;
    localparam int ST_PERIODIC = 3;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [SLICE_W-1:0] slc;
    } t_elem_beat;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   column;
        logic [SLICE_W-1:0] slc;
        logic               last;
    } t_cov_elem;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [VAL_W-1:0]   i_value = '0;
    logic [SLICE_W-1:0] i_slice = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [VAL_W-1:0]   o_result_value;
    logic [IDX_W-1:0]   o_row;
    logic [IDX_W-1:0]   o_column;
    logic [SLICE_W-1:0] o_result_slice;
    logic               o_last;

    covariance_transform_a_p_at_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_slice        (i_slice),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_result_slice (o_result_slice),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    t_elem_beat pending_beats[$];
    t_cov_elem  expected_cov[$];

    logic signed [VAL_W-1:0] a_mat [CELLS];
    logic signed [VAL_W-1:0] p_mat [CELLS];
    logic [SLICE_W-1:0]      a_tag;
    int                      beats_loaded;

    int mismatch_cnt    = 0;
    int results_checked = 0;
    int jobs_predicted  = 0;
    int sat_predicted   = 0;
    int beats_sent      = 0;
    int in_stall_cycles = 0;
    int cycle_cnt       = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 50) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    function automatic void propagate_covariance();
        logic signed [127:0] acc;
        logic signed [63:0]  x_prod [CELLS];
        t_cov_elem           e;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = '0;
                for (int k = 0; k < DIM; k++) begin
                    acc = acc + a_mat[i * DIM + k] * p_mat[k * DIM + j];
                end
                acc = (acc + 128'sd32768) >>> FRAC;
                x_prod[i * DIM + j] = acc[63:0];
            end
        end
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = '0;
                for (int k = 0; k < DIM; k++) begin
                    acc = acc + x_prod[i * DIM + k] * a_mat[j * DIM + k];
                end
                acc = (acc + 128'sd32768) >>> FRAC;
                if (acc > 128'sd2147483647) begin
                    e.value = SAT_MAX;
                    sat_predicted++;
                end else if (acc < -128'sd2147483648) begin
                    e.value = SAT_MIN;
                    sat_predicted++;
                end else begin
                    e.value = acc[VAL_W-1:0];
                end
                e.row    = IDX_W'(i);
                e.column = IDX_W'(j);
                e.slc    = a_tag;
                e.last   = (i == DIM - 1) && (j == DIM - 1);
                expected_cov.push_back(e);
            end
        end
        jobs_predicted++;
    endfunction

    function automatic void load_matrix_beat(logic [VAL_W-1:0] value, logic [SLICE_W-1:0] slc);
        logic [SLICE_W-1:0] s;
        s = (int'(slc) >= PLANES) ? SLICE_W'(PLANES - 1) : slc;
        if (beats_loaded < CELLS) begin
            a_mat[beats_loaded] = value;
            a_tag = s;
            beats_loaded++;
        end else begin
            p_mat[beats_loaded - CELLS] = value;
            beats_loaded++;
            if (beats_loaded == 2 * CELLS) begin
                beats_loaded = 0;
                propagate_covariance();
            end
        end
    endfunction

    function automatic logic [VAL_W-1:0] pick_element(int kind);
        int sel;
        sel = (kind == EL_MIXED) ? int'($urandom_range(0, 3)) : kind;
        case (sel)
            EL_SMALL: begin
                return VAL_W'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
            end
            EL_CORNER: begin
                case ($urandom_range(0, 6))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h00000000;
                    3: return 32'hFFFFFFFF;
                    4: return 32'h00000001;
                    5: return 32'h00010000;
                    default: return 32'hFFFF0000;
                endcase
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_elem_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_stall) begin
                in_stall_cycles++;
            end
            if (i_valid && !o_stall) begin
                load_matrix_beat(i_value, i_slice);
                beats_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    i_valid <= 1'b1;
                    i_value <= b.value;
                    i_slice <= b.slc;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, after the first results have come through
    int   hold_cnt  = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && results_checked >= 30) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // receiver: stall pattern and result check
    int        stall_mode = ST_NONE;
    int        mode_left  = 0;
    t_cov_elem want;

    always @(posedge i_clk) begin
        logic pat;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(ST_NONE, ST_PERIODIC);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                ST_RANDOM:   pat = ($urandom_range(0, 2) == 0);
                ST_HEAVY:    pat = ($urandom_range(0, 3) != 0);
                ST_PERIODIC: pat = (cycle_cnt % 3 == 0);
                default:     pat = 1'b0;
            endcase
            i_stall <= pat || (hold_cnt != 0);

            if (o_valid && !i_stall) begin
                if (expected_cov.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected beat value %h row %0d col %0d slice %0d last %0b",
                        o_result_value, o_row, o_column, o_result_slice, o_last));
                end else begin
                    want = expected_cov.pop_front();
                    if (o_result_value !== want.value || o_row !== want.row ||
                        o_column !== want.column || o_result_slice !== want.slc ||
                        o_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got %h r%0d c%0d s%0d l%0b, exp %h r%0d c%0d s%0d l%0b",
                            o_result_value, o_row, o_column, o_result_slice, o_last,
                            want.value, want.row, want.column, want.slc, want.last));
                    end
                    results_checked <= results_checked + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_cov.size());
            $display("covariance_transform_a_p_at_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [VAL_W-1:0] corner_vals [10];
        t_elem_beat       b;
        int               kind;
        int               pick;

        beats_loaded = 0;
        a_tag        = '0;
        corner_vals  = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
                         32'h00010000, 32'hFFFF0000, 32'h00018000, 32'h00000001,
                         32'h80000001, 32'h7FFF0000};

        // directed job: corner values in the first rows; A is identity below
        for (int idx = 0; idx < CELLS; idx++) begin
            if (idx < 10) begin
                b.value = corner_vals[idx];
            end else begin
                b.value = (idx % (DIM + 1) == 0) ? 32'h00010000 : 32'h00000000;
            end
            b.slc = SLICE_W'((idx + 5) % 8);
            pending_beats.push_back(b);
        end
        for (int idx = 0; idx < CELLS; idx++) begin
            if (idx < 10) begin
                b.value = corner_vals[9 - idx];
            end else begin
                b.value = (idx % (DIM + 1) == 0) ? 32'hFFFF8000 : 32'h00004000;
            end
            b.slc = SLICE_W'(7 - (idx % 8));
            pending_beats.push_back(b);
        end

        // random jobs: mostly small Q16.16 values, some corner-heavy or full range
        for (int job = 1; job < JOBS; job++) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? EL_SMALL : (pick < 8) ? EL_MIXED : EL_WIDE;
            for (int idx = 0; idx < 2 * CELLS; idx++) begin
                b.value = pick_element(kind);
                b.slc   = SLICE_W'($urandom_range(0, 7));
                pending_beats.push_back(b);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_cov.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d jobs from %0d beats, %0d result beats checked (%0d saturated)",
                 jobs_predicted, beats_sent, results_checked, sat_predicted);
        $display("input held off for %0d cycles; long output hold-off %0s",
                 in_stall_cycles, hold_done ? "applied" : "not reached");
        if (mismatch_cnt == 0) begin
            $display("covariance_transform_a_p_at_core: match");
        end else begin
            $display("covariance_transform_a_p_at_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ctapat_pkg.sv
rtl/core/ctapat_ctrl.sv
rtl/core/ctapat_dp.sv
rtl/core/covariance_transform_a_p_at_core.sv
sim/testbench.sv
